// ----- rtl/swst_pkg.sv -----
// Shared constants, codes and types of the sliding window sender tracker.
package swst_pkg;

	localparam int WINDOW_SIZE = 4;
	localparam int SEQ_W       = 32;
	localparam int LEN_W       = 8;
	localparam int TMR_W       = 16;
	localparam int CMD_W       = 2;
	localparam int STAT_W      = 3;
	localparam int MARK_W      = 2;
	localparam int PADDR_W     = 3;
	localparam int PDATA_W     = 32;

	localparam logic [TMR_W-1:0] TIMEOUT_RST = TMR_W'(1000);

	localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ACK  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

	localparam logic [STAT_W-1:0] STAT_SENT   = 3'd0;
	localparam logic [STAT_W-1:0] STAT_FULL   = 3'd1;
	localparam logic [STAT_W-1:0] STAT_ACKED  = 3'd2;
	localparam logic [STAT_W-1:0] STAT_RETX   = 3'd3;
	localparam logic [STAT_W-1:0] STAT_FINISH = 3'd4;

	localparam logic [MARK_W-1:0] MARK_FREE = 2'd0;
	localparam logic [MARK_W-1:0] MARK_OUT  = 2'd1;
	localparam logic [MARK_W-1:0] MARK_DONE = 2'd2;

	localparam logic [2:0] OP_HOLD  = 3'd0;
	localparam logic [2:0] OP_SEND  = 3'd1;
	localparam logic [2:0] OP_ACK   = 3'd2;
	localparam logic [2:0] OP_TICK  = 3'd3;
	localparam logic [2:0] OP_SHIFT = 3'd4;

	typedef struct packed {
		logic [MARK_W-1:0] mark;
		logic [SEQ_W-1:0]  pending;
		logic [TMR_W-1:0]  timer;
	} cell_state_t;

	typedef struct packed {
		logic [2:0]       op;
		logic [SEQ_W-1:0] key;
		logic [TMR_W-1:0] timeout;
	} cell_ctrl_t;

endpackage

// ----- rtl/swst_cell.sv -----
// One window slot: awaited ack, slot mark, retransmit timer and due flag.
module swst_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swst_pkg::cell_ctrl_t  ctrl,
	input  logic                  prev_busy,
	input  swst_pkg::cell_state_t right,
	input  logic                  take,
	output swst_pkg::cell_state_t state,
	output logic                  due
);
	import swst_pkg::*;

	logic [MARK_W-1:0] mark_q;
	logic [SEQ_W-1:0]  pending_q;
	logic [TMR_W-1:0]  timer_q;
	logic              due_q;
	logic              is_target;
	logic              hit;
	logic [TMR_W:0]    aged;

	assign is_target = prev_busy && (mark_q == MARK_FREE);
	assign hit       = (mark_q == MARK_OUT) && (pending_q == ctrl.key);
	assign aged      = {1'b0, timer_q} + (TMR_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q  <= MARK_FREE;
			timer_q <= '0;
			due_q   <= 1'b0;
		end else begin
			if (take) begin
				due_q <= 1'b0;
			end
			case (ctrl.op)
				OP_SEND: begin
					if (is_target) begin
						mark_q  <= MARK_OUT;
						timer_q <= '0;
					end
				end
				OP_ACK: begin
					if (hit) begin
						mark_q  <= MARK_DONE;
						timer_q <= '0;
					end
				end
				OP_TICK: begin
					if (mark_q == MARK_OUT) begin
						if (aged >= {1'b0, ctrl.timeout}) begin
							timer_q <= '0;
							due_q   <= 1'b1;
						end else begin
							timer_q <= aged[TMR_W-1:0];
						end
					end
				end
				OP_SHIFT: begin
					mark_q  <= right.mark;
					timer_q <= right.timer;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.op == OP_SEND && is_target) begin
			pending_q <= ctrl.key;
		end else if (ctrl.op == OP_SHIFT) begin
			pending_q <= right.pending;
		end
	end

	assign state.mark    = mark_q;
	assign state.pending = pending_q;
	assign state.timer   = timer_q;
	assign due           = due_q;

`ifndef SYNTHESIS
	a_free_tail: assert property (@(posedge clk) disable iff (!arst_n)
		!prev_busy |-> mark_q == MARK_FREE)
		else $error("occupied slot behind a free slot");
	a_free_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mark_q == MARK_FREE |-> (timer_q == '0) && !due_q)
		else $error("free slot with running timer or due flag");
`endif

endmodule

// ----- rtl/sliding_window_sender_tracker.sv -----
// Top level of the sliding window sender tracker: window cell chain, control and APB register.
//
// Tracks up to WINDOW_SIZE outstanding byte-numbered segments in a chain of
// slot cells, each with its own awaited ack and retransmit timer. One input
// beat is handled at a time; in_stall is high while a beat is in progress.
// A send, a refused send or any known beat after finishing goes through the
// result registers and done state to the output register. An ack slides done
// slots out of the window front, one per cycle (at most WINDOW_SIZE), then goes
// out via the done state. A tick ages all timers, then emits one retransmit beat
// per expired slot, one per cycle while out_stall allows, in slot order; a tick
// with nothing due gives no beat. The output register lets a new input beat be
// taken while a result waits on out_stall. timeout_ticks sits at byte address 0.
module sliding_window_sender_tracker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [swst_pkg::PADDR_W-1:0]   paddr,
	input  logic [swst_pkg::PDATA_W-1:0]   pwdata,
	output logic [swst_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [swst_pkg::CMD_W-1:0]     command,
	input  logic [swst_pkg::LEN_W-1:0]     seg_length,
	input  logic [swst_pkg::SEQ_W-1:0]     ack_number,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [swst_pkg::STAT_W-1:0]    status,
	output logic [swst_pkg::SEQ_W-1:0]     seq_start,
	output logic [swst_pkg::SEQ_W-1:0]     expected_ack,
	output logic [swst_pkg::SEQ_W-1:0]     window_base,
	output logic                           all_acked,
	output logic                           last_of_run
);
	import swst_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SLIDE = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	localparam cell_state_t FREE_CELL = '{mark: MARK_FREE, pending: '0, timer: '0};

	logic [1:0]        state_q;
	logic [TMR_W-1:0]  timeout_q;
	logic [SEQ_W-1:0]  next_seq_q;
	logic [SEQ_W-1:0]  final_seq_q;
	logic              final_seen_q;
	logic              finished_q;
	logic [STAT_W-1:0] res_status_q;
	logic [SEQ_W-1:0]  res_seq_q;
	logic [SEQ_W-1:0]  res_exp_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [SEQ_W-1:0]  seq_start_q;
	logic [SEQ_W-1:0]  expected_ack_q;
	logic [SEQ_W-1:0]  window_base_q;
	logic              all_acked_q;
	logic              last_of_run_q;

	cell_state_t             cells  [WINDOW_SIZE];
	cell_state_t             rights [WINDOW_SIZE];
	logic [WINDOW_SIZE-1:0]  prev_busy;
	logic [WINDOW_SIZE-1:0]  due_v;
	logic [WINDOW_SIZE-1:0]  take_v;
	logic [WINDOW_SIZE-1:0]  lowest;
	cell_ctrl_t              ctrl;

	logic              accept;
	logic              out_free;
	logic              full;
	logic              cfg_wr;
	logic [SEQ_W-1:0]  seq_next;
	logic [SEQ_W-1:0]  base_now;
	logic [SEQ_W-1:0]  due_ack;
	logic              due_last;

	// APB register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[PADDR_W-1] == 1'b0) ? {{(PDATA_W-TMR_W){1'b0}}, timeout_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_wr && paddr[PADDR_W-1] == 1'b0) begin
			timeout_q <= pwdata[TMR_W-1:0];
		end
	end

	// cell chain
	genvar g;
	generate
		for (g = 0; g < WINDOW_SIZE; g++) begin : g_cell
			if (g == 0) begin : g_head
				assign prev_busy[g] = 1'b1;
			end else begin : g_body
				assign prev_busy[g] = (cells[g-1].mark != MARK_FREE);
			end
			if (g == WINDOW_SIZE-1) begin : g_tail
				assign rights[g] = FREE_CELL;
			end else begin : g_link
				assign rights[g] = cells[g+1];
			end
			swst_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctrl      (ctrl),
				.prev_busy (prev_busy[g]),
				.right     (rights[g]),
				.take      (take_v[g]),
				.state     (cells[g]),
				.due       (due_v[g])
			);
		end
	endgenerate

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign full     = (cells[WINDOW_SIZE-1].mark != MARK_FREE);
	assign seq_next = next_seq_q + {{(SEQ_W-LEN_W){1'b0}}, seg_length};
	assign base_now = (cells[0].mark == MARK_OUT) ? cells[0].pending : next_seq_q;

	assign lowest   = due_v & (~due_v + WINDOW_SIZE'(1));
	assign take_v   = (state_q == ST_EMIT && out_free) ? lowest : '0;
	assign due_last = ((due_v & ~lowest) == '0);

	always_comb begin
		due_ack = '0;
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			due_ack = due_ack | (cells[i].pending & {SEQ_W{lowest[i]}});
		end
	end

	always_comb begin
		ctrl.op      = OP_HOLD;
		ctrl.key     = (command == CMD_SEND) ? seq_next : ack_number;
		ctrl.timeout = timeout_q;
		if (accept && !finished_q) begin
			case (command)
				CMD_SEND: ctrl.op = full ? OP_HOLD : OP_SEND;
				CMD_ACK:  ctrl.op = OP_ACK;
				CMD_TICK: ctrl.op = OP_TICK;
				default:  ctrl.op = OP_HOLD;
			endcase
		end else if (state_q == ST_SLIDE && cells[0].mark == MARK_DONE) begin
			ctrl.op = OP_SHIFT;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			next_seq_q   <= '0;
			final_seq_q  <= '0;
			final_seen_q <= 1'b0;
			finished_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && command != CMD_SEND && command != CMD_ACK
					    && command != CMD_TICK) begin
						state_q <= ST_IDLE;
					end else if (accept && finished_q) begin
						state_q <= ST_DONE;
					end else if (accept) begin
						case (command)
							CMD_SEND: begin
								state_q <= ST_DONE;
								if (!full) begin
									next_seq_q <= seq_next;
									if (seg_length == '0) begin
										final_seq_q  <= seq_next;
										final_seen_q <= 1'b1;
									end
								end
							end
							CMD_ACK: begin
								state_q <= ST_SLIDE;
								if (final_seen_q && ack_number == final_seq_q) begin
									finished_q <= 1'b1;
								end
							end
							default: state_q <= ST_EMIT;
						endcase
					end
				end
				ST_SLIDE: begin
					if (cells[0].mark != MARK_DONE) begin
						state_q <= ST_DONE;
					end
				end
				ST_EMIT: begin
					if (due_v == '0 || (out_free && due_last)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_seq_q <= '0;
			res_exp_q <= '0;
			if (finished_q) begin
				res_status_q <= STAT_FINISH;
			end else if (command == CMD_SEND) begin
				if (full) begin
					res_status_q <= STAT_FULL;
				end else begin
					res_status_q <= STAT_SENT;
					res_seq_q    <= next_seq_q;
					res_exp_q    <= seq_next;
				end
			end else begin
				res_status_q <= STAT_ACKED;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (state_q == ST_EMIT && out_free && due_v != '0) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			status_q       <= res_status_q;
			seq_start_q    <= res_seq_q;
			expected_ack_q <= res_exp_q;
			window_base_q  <= base_now;
			all_acked_q    <= finished_q;
			last_of_run_q  <= 1'b1;
		end else if (state_q == ST_EMIT && out_free && due_v != '0) begin
			status_q       <= STAT_RETX;
			seq_start_q    <= '0;
			expected_ack_q <= due_ack;
			window_base_q  <= base_now;
			all_acked_q    <= finished_q;
			last_of_run_q  <= due_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign seq_start    = seq_start_q;
	assign expected_ack = expected_ack_q;
	assign window_base  = window_base_q;
	assign all_acked    = all_acked_q;
	assign last_of_run  = last_of_run_q;

`ifndef SYNTHESIS
	a_due_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(due_v != '0) |-> state_q == ST_EMIT)
		else $error("retransmit pending outside emit phase");
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |=> finished_q)
		else $error("finished flag dropped");
`endif

endmodule
